// File: hw/rtl/fbsl_pkg.sv
package fbsl_pkg;

  // Byte offsets of the boot sector fields that are captured.
  localparam int OFFSET_W = 9;
  localparam logic [OFFSET_W-1:0] OFFSET_MAX        = 9'd511;
  localparam logic [OFFSET_W-1:0] OFS_SECTOR_SIZE   = 9'h00B;
  localparam logic [OFFSET_W-1:0] OFS_CLUSTER_SECS  = 9'h00D;
  localparam logic [OFFSET_W-1:0] OFS_RESERVED      = 9'h00E;
  localparam logic [OFFSET_W-1:0] OFS_FAT_COUNT     = 9'h010;
  localparam logic [OFFSET_W-1:0] OFS_ROOT_ENTRIES  = 9'h011;
  localparam logic [OFFSET_W-1:0] OFS_TOTAL_SHORT   = 9'h013;
  localparam logic [OFFSET_W-1:0] OFS_FAT_SIZE_SHORT = 9'h016;
  localparam logic [OFFSET_W-1:0] OFS_TOTAL_LONG    = 9'h020;
  localparam logic [OFFSET_W-1:0] OFS_FAT_SIZE_LONG = 9'h024;
  localparam logic [OFFSET_W-1:0] OFS_ROOT_CLUSTER  = 9'h02C;

  localparam int DIR_ENTRY_BYTES = 32;
  localparam int DIR_SHIFT       = $clog2(DIR_ENTRY_BYTES);

  // Both dividers retire one quotient bit per step over a 32-bit dividend.
  localparam int DIV_W = 32;
  localparam int STEP_W = $clog2(DIV_W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_W - 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] KIND_FAT12 = 2'd0;
  localparam logic [1:0] KIND_FAT16 = 2'd1;
  localparam logic [1:0] KIND_FAT32 = 2'd2;

  localparam logic CFG_FAT12_LIMIT = 1'b0;
  localparam logic CFG_FAT16_LIMIT = 1'b1;
  localparam logic [31:0] FAT12_LIMIT_RESET = 32'd4085;
  localparam logic [31:0] FAT16_LIMIT_RESET = 32'd65525;

  typedef struct packed {
    logic [7:0] sector_byte;
    logic       sector_end;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  fat_kind;
    logic [15:0] sector_size;
    logic [7:0]  cluster_sectors;
    logic [15:0] fat_region_start;
    logic [39:0] fat_region_sectors;
    logic [40:0] root_region_start;
    logic [20:0] root_region_sectors;
    logic [40:0] data_region_start;
    logic [31:0] root_start_cluster;
    logic [31:0] cluster_total;
    logic        geometry_error;
  } out_word_t;

  // One parsed sector waiting for the back end.
  typedef struct packed {
    logic [15:0] sector_size;
    logic [7:0]  cluster_sectors;
    logic [15:0] reserved;
    logic [7:0]  fat_count;
    logic [15:0] root_entries;
    logic [31:0] total;
    logic [31:0] fat_size;
    logic [31:0] root_cluster;
  } job_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } queue_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_SUM,
    BK_EMIT
  } back_state_t;

endpackage

// File: hw/rtl/fbsl_front.sv
module fbsl_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  fbsl_pkg::in_word_t in_data,
  output logic              push,
  output fbsl_pkg::job_t    push_job
);

  logic [fbsl_pkg::OFFSET_W-1:0] offset_r, offset_nxt;
  logic [15:0] sector_size_r, sector_size_nxt;
  logic [7:0]  cluster_secs_r, cluster_secs_nxt;
  logic [15:0] reserved_r, reserved_nxt;
  logic [7:0]  fat_count_r, fat_count_nxt;
  logic [15:0] root_entries_r, root_entries_nxt;
  logic [15:0] total_short_r, total_short_nxt;
  logic [15:0] fat_size_short_r, fat_size_short_nxt;
  logic [31:0] total_long_r, total_long_nxt;
  logic [31:0] fat_size_long_r, fat_size_long_nxt;
  logic [31:0] root_cluster_r, root_cluster_nxt;
  logic        accept;
  logic [7:0]  b;

  assign accept = in_valid && !in_stall;
  assign b = in_data.sector_byte;

  always_comb begin
    offset_nxt         = offset_r;
    sector_size_nxt    = sector_size_r;
    cluster_secs_nxt   = cluster_secs_r;
    reserved_nxt       = reserved_r;
    fat_count_nxt      = fat_count_r;
    root_entries_nxt   = root_entries_r;
    total_short_nxt    = total_short_r;
    fat_size_short_nxt = fat_size_short_r;
    total_long_nxt     = total_long_r;
    fat_size_long_nxt  = fat_size_long_r;
    root_cluster_nxt   = root_cluster_r;
    push               = 1'b0;
    if (accept) begin
      case (offset_r)
        fbsl_pkg::OFS_SECTOR_SIZE:           sector_size_nxt[7:0]     = b;
        fbsl_pkg::OFS_SECTOR_SIZE + 9'd1:    sector_size_nxt[15:8]    = b;
        fbsl_pkg::OFS_CLUSTER_SECS:          cluster_secs_nxt         = b;
        fbsl_pkg::OFS_RESERVED:              reserved_nxt[7:0]        = b;
        fbsl_pkg::OFS_RESERVED + 9'd1:       reserved_nxt[15:8]       = b;
        fbsl_pkg::OFS_FAT_COUNT:             fat_count_nxt            = b;
        fbsl_pkg::OFS_ROOT_ENTRIES:          root_entries_nxt[7:0]    = b;
        fbsl_pkg::OFS_ROOT_ENTRIES + 9'd1:   root_entries_nxt[15:8]   = b;
        fbsl_pkg::OFS_TOTAL_SHORT:           total_short_nxt[7:0]     = b;
        fbsl_pkg::OFS_TOTAL_SHORT + 9'd1:    total_short_nxt[15:8]    = b;
        fbsl_pkg::OFS_FAT_SIZE_SHORT:        fat_size_short_nxt[7:0]  = b;
        fbsl_pkg::OFS_FAT_SIZE_SHORT + 9'd1: fat_size_short_nxt[15:8] = b;
        fbsl_pkg::OFS_TOTAL_LONG:            total_long_nxt[7:0]      = b;
        fbsl_pkg::OFS_TOTAL_LONG + 9'd1:     total_long_nxt[15:8]     = b;
        fbsl_pkg::OFS_TOTAL_LONG + 9'd2:     total_long_nxt[23:16]    = b;
        fbsl_pkg::OFS_TOTAL_LONG + 9'd3:     total_long_nxt[31:24]    = b;
        fbsl_pkg::OFS_FAT_SIZE_LONG:         fat_size_long_nxt[7:0]   = b;
        fbsl_pkg::OFS_FAT_SIZE_LONG + 9'd1:  fat_size_long_nxt[15:8]  = b;
        fbsl_pkg::OFS_FAT_SIZE_LONG + 9'd2:  fat_size_long_nxt[23:16] = b;
        fbsl_pkg::OFS_FAT_SIZE_LONG + 9'd3:  fat_size_long_nxt[31:24] = b;
        fbsl_pkg::OFS_ROOT_CLUSTER:          root_cluster_nxt[7:0]    = b;
        fbsl_pkg::OFS_ROOT_CLUSTER + 9'd1:   root_cluster_nxt[15:8]   = b;
        fbsl_pkg::OFS_ROOT_CLUSTER + 9'd2:   root_cluster_nxt[23:16]  = b;
        fbsl_pkg::OFS_ROOT_CLUSTER + 9'd3:   root_cluster_nxt[31:24]  = b;
        default: ;
      endcase
      if (in_data.sector_end) begin
        offset_nxt = '0;
        push       = 1'b1;
      end else if (offset_r != fbsl_pkg::OFFSET_MAX) begin
        offset_nxt = offset_r + 9'd1;
      end
    end
  end

  // The job carries the values including the final byte of the sector.
  always_comb begin
    push_job.sector_size     = sector_size_nxt;
    push_job.cluster_sectors = cluster_secs_nxt;
    push_job.reserved        = reserved_nxt;
    push_job.fat_count       = fat_count_nxt;
    push_job.root_entries    = root_entries_nxt;
    push_job.total           = (total_short_nxt != 16'd0) ? {16'd0, total_short_nxt}
                                                          : total_long_nxt;
    push_job.fat_size        = (fat_size_short_nxt != 16'd0) ? {16'd0, fat_size_short_nxt}
                                                             : fat_size_long_nxt;
    push_job.root_cluster    = root_cluster_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r         <= '0;
      sector_size_r    <= '0;
      cluster_secs_r   <= '0;
      reserved_r       <= '0;
      fat_count_r      <= '0;
      root_entries_r   <= '0;
      total_short_r    <= '0;
      fat_size_short_r <= '0;
      total_long_r     <= '0;
      fat_size_long_r  <= '0;
      root_cluster_r   <= '0;
    end else begin
      offset_r         <= offset_nxt;
      sector_size_r    <= sector_size_nxt;
      cluster_secs_r   <= cluster_secs_nxt;
      reserved_r       <= reserved_nxt;
      fat_count_r      <= fat_count_nxt;
      root_entries_r   <= root_entries_nxt;
      total_short_r    <= total_short_nxt;
      fat_size_short_r <= fat_size_short_nxt;
      total_long_r     <= total_long_nxt;
      fat_size_long_r  <= fat_size_long_nxt;
      root_cluster_r   <= root_cluster_nxt;
    end
  end

endmodule

// File: hw/rtl/fbsl_queue.sv
module fbsl_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  fbsl_pkg::job_t          push_job,
  input  logic                    pop,
  output fbsl_pkg::job_t          head_job,
  output fbsl_pkg::queue_status_t status
);

  fbsl_pkg::job_t                entries_r [fbsl_pkg::QUEUE_DEPTH];
  logic [fbsl_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [fbsl_pkg::QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [fbsl_pkg::QCNT_W-1:0]   count_r, count_nxt;
  logic                          do_push, do_pop;

  assign status.full      = (count_r == fbsl_pkg::QCNT_W'(fbsl_pkg::QUEUE_DEPTH));
  assign status.not_empty = (count_r != '0);
  assign head_job         = entries_r[rd_ptr_r];

  assign do_push = push && !status.full;
  assign do_pop  = pop && status.not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == fbsl_pkg::QPTR_W'(fbsl_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                             : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == fbsl_pkg::QPTR_W'(fbsl_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                             : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// File: hw/rtl/fbsl_back.sv
module fbsl_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  fbsl_pkg::queue_status_t q_status,
  input  fbsl_pkg::job_t          head_job,
  output logic                    pop,
  input  logic [31:0]             fat12_limit,
  input  logic [31:0]             fat16_limit,
  output logic                    out_valid,
  input  logic                    out_stall,
  output fbsl_pkg::out_word_t     out_data
);

  fbsl_pkg::back_state_t state_r, state_nxt;
  logic [fbsl_pkg::STEP_W-1:0] step_r, step_nxt;
  fbsl_pkg::job_t              job_r, job_nxt;

  // Cluster count divider: 32-bit dividend, 8-bit divisor.
  logic [31:0] dvd1_r, dvd1_nxt;
  logic [7:0]  rem1_r, rem1_nxt;
  logic [8:0]  trial1;
  logic        ge1;
  // Root directory sector divider: padded 22-bit dividend, 16-bit divisor.
  logic [31:0] dvd2_r, dvd2_nxt;
  logic [15:0] rem2_r, rem2_nxt;
  logic [16:0] trial2;
  logic        ge2;
  logic [21:0] root_bytes;

  logic [39:0] fat_secs_r, fat_secs_nxt;
  logic [40:0] root_start_r, root_start_nxt;
  logic [20:0] root_secs_r, root_secs_nxt;
  logic [31:0] clusters_r, clusters_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic        err_r, err_nxt;

  fbsl_pkg::out_word_t out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic load, div_en, sum_en, emit_en, out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fbsl_pkg::BK_IDLE: if (q_status.not_empty) state_nxt = fbsl_pkg::BK_DIV;
      fbsl_pkg::BK_DIV:  if (step_r == fbsl_pkg::STEP_LAST) state_nxt = fbsl_pkg::BK_SUM;
      fbsl_pkg::BK_SUM:  state_nxt = fbsl_pkg::BK_EMIT;
      fbsl_pkg::BK_EMIT: if (out_free) state_nxt = fbsl_pkg::BK_IDLE;
      default:           state_nxt = fbsl_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    load    = 1'b0;
    div_en  = 1'b0;
    sum_en  = 1'b0;
    emit_en = 1'b0;
    case (state_r)
      fbsl_pkg::BK_IDLE: load    = q_status.not_empty;
      fbsl_pkg::BK_DIV:  div_en  = 1'b1;
      fbsl_pkg::BK_SUM:  sum_en  = 1'b1;
      fbsl_pkg::BK_EMIT: emit_en = out_free;
      default: ;
    endcase
  end

  assign pop = load;

  assign trial1 = {rem1_r, dvd1_r[31]};
  assign ge1    = trial1 >= {1'b0, job_r.cluster_sectors};
  assign trial2 = {rem2_r, dvd2_r[31]};
  assign ge2    = trial2 >= {1'b0, job_r.sector_size};
  // Rounding up: entries * 32 + sector_size - 1 never exceeds 22 bits.
  assign root_bytes = {1'b0, head_job.root_entries, {fbsl_pkg::DIR_SHIFT{1'b0}}}
                    + {6'd0, head_job.sector_size - 16'd1};

  always_comb begin
    step_nxt       = step_r;
    job_nxt        = job_r;
    dvd1_nxt       = dvd1_r;
    rem1_nxt       = rem1_r;
    dvd2_nxt       = dvd2_r;
    rem2_nxt       = rem2_r;
    fat_secs_nxt   = fat_secs_r;
    root_start_nxt = root_start_r;
    root_secs_nxt  = root_secs_r;
    clusters_nxt   = clusters_r;
    kind_nxt       = kind_r;
    err_nxt        = err_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && out_stall;

    if (load) begin
      job_nxt  = head_job;
      step_nxt = '0;
      dvd1_nxt = head_job.total;
      rem1_nxt = '0;
      dvd2_nxt = {10'd0, root_bytes};
      rem2_nxt = '0;
    end

    if (div_en) begin
      step_nxt     = step_r + 1'b1;
      rem1_nxt     = ge1 ? 8'(trial1 - {1'b0, job_r.cluster_sectors}) : trial1[7:0];
      dvd1_nxt     = {dvd1_r[30:0], ge1};
      rem2_nxt     = ge2 ? 16'(trial2 - {1'b0, job_r.sector_size}) : trial2[15:0];
      dvd2_nxt     = {dvd2_r[30:0], ge2};
      fat_secs_nxt = {8'd0, job_r.fat_size} * {32'd0, job_r.fat_count};
    end

    if (sum_en) begin
      // A zero divisor leaves an all-ones quotient; it is replaced by zero.
      clusters_nxt   = (job_r.cluster_sectors != 8'd0) ? dvd1_r : 32'd0;
      root_secs_nxt  = (job_r.sector_size != 16'd0) ? dvd2_r[20:0] : 21'd0;
      root_start_nxt = {25'd0, job_r.reserved} + {1'b0, fat_secs_r};
      err_nxt        = (job_r.cluster_sectors == 8'd0) || (job_r.sector_size == 16'd0);
      if (clusters_nxt < fat12_limit) begin
        kind_nxt = fbsl_pkg::KIND_FAT12;
      end else if (clusters_nxt < fat16_limit) begin
        kind_nxt = fbsl_pkg::KIND_FAT16;
      end else begin
        kind_nxt = fbsl_pkg::KIND_FAT32;
      end
    end

    if (emit_en) begin
      out_valid_nxt               = 1'b1;
      out_nxt.fat_kind            = kind_r;
      out_nxt.sector_size         = job_r.sector_size;
      out_nxt.cluster_sectors     = job_r.cluster_sectors;
      out_nxt.fat_region_start    = job_r.reserved;
      out_nxt.fat_region_sectors  = fat_secs_r;
      out_nxt.root_region_start   = root_start_r;
      out_nxt.root_region_sectors = root_secs_r;
      out_nxt.data_region_start   = root_start_r + {20'd0, root_secs_r};
      out_nxt.root_start_cluster  = (kind_r == fbsl_pkg::KIND_FAT32) ? job_r.root_cluster
                                                                    : 32'd0;
      out_nxt.cluster_total       = clusters_r;
      out_nxt.geometry_error      = err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fbsl_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r       <= step_nxt;
    job_r        <= job_nxt;
    dvd1_r       <= dvd1_nxt;
    rem1_r       <= rem1_nxt;
    dvd2_r       <= dvd2_nxt;
    rem2_r       <= rem2_nxt;
    fat_secs_r   <= fat_secs_nxt;
    root_start_r <= root_start_nxt;
    root_secs_r  <= root_secs_nxt;
    clusters_r   <= clusters_nxt;
    kind_r       <= kind_nxt;
    err_r        <= err_nxt;
    out_r        <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: hw/rtl/fat_boot_sector_layout.sv
// Boot sector parser for FAT volumes. Bytes of a sector are taken one per
// cycle while in_stall is low, in offset order; the front end captures the
// BPB fields and, on the byte marked sector_end, hands a snapshot to a
// two-entry queue. The back end works on one sector at a time: a load step,
// two bit-serial dividers (cluster count and root directory sectors, run
// side by side), the adds and limit compares, and an emit step that waits
// out a stalled output word. Bytes keep streaming while the back end runs;
// in_stall rises only when the queue already holds two finished sectors.
// The cluster limits are to be written through the cfg port while no sector
// is in flight; the block itself does not enforce this.
module fat_boot_sector_layout (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fbsl_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output fbsl_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_data
);

  logic                    push, pop;
  fbsl_pkg::job_t          push_job, head_job;
  fbsl_pkg::queue_status_t q_status;
  logic [31:0]             fat12_limit_r, fat12_limit_nxt;
  logic [31:0]             fat16_limit_r, fat16_limit_nxt;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_status.full;

  always_comb begin
    fat12_limit_nxt = fat12_limit_r;
    fat16_limit_nxt = fat16_limit_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fbsl_pkg::CFG_FAT12_LIMIT: fat12_limit_nxt = cfg_data;
        fbsl_pkg::CFG_FAT16_LIMIT: fat16_limit_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fat12_limit_r <= fbsl_pkg::FAT12_LIMIT_RESET;
      fat16_limit_r <= fbsl_pkg::FAT16_LIMIT_RESET;
    end else begin
      fat12_limit_r <= fat12_limit_nxt;
      fat16_limit_r <= fat16_limit_nxt;
    end
  end

  fbsl_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .push     (push),
    .push_job (push_job)
  );

  fbsl_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .status   (q_status)
  );

  fbsl_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_status    (q_status),
    .head_job    (head_job),
    .pop         (pop),
    .fat12_limit (fat12_limit_r),
    .fat16_limit (fat16_limit_r),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

// File: hw/rtl/fbsl_checker.sv
module fbsl_assert_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input fbsl_pkg::out_word_t out_data
);

  // A stalled result word stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result word changed while stalled");

  // Only a FAT32 volume reports a root cluster.
  a_root_cluster: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.fat_kind != fbsl_pkg::KIND_FAT32)
      |-> (out_data.root_start_cluster == 32'd0))
    else $error("root cluster reported for a non-FAT32 volume");

  // A zero cluster size flags an error and gives no clusters.
  a_zero_cluster: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.cluster_sectors == 8'd0)
      |-> out_data.geometry_error && (out_data.cluster_total == 32'd0))
    else $error("zero cluster size not handled");

  a_region_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.data_region_start >= out_data.root_region_start))
    else $error("data region starts before root region");

endmodule

bind fat_boot_sector_layout fbsl_assert_checker u_fbsl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: verif/fbsl_checker.sv
`timescale 1ns / 100ps

module fbsl_checker
  import fbsl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  in_word_t   in_data,
  input  logic       out_valid,
  input  logic       out_stall,
  input  out_word_t  out_data,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [31:0] cfg_data,
  output int         mismatch_count,
  output int         layouts_waiting,
  output int         layouts_checked
);

  logic [31:0] fat12_limit;
  logic [31:0] fat16_limit;

  logic [OFFSET_W-1:0] offset;
  logic [15:0] bps;
  logic [7:0]  spc;
  logic [15:0] rsv;
  logic [7:0]  nfats;
  logic [15:0] root_entries;
  logic [15:0] total_short;
  logic [15:0] fat_size_short;
  logic [31:0] total_long;
  logic [31:0] fat_size_long;
  logic [31:0] root_cluster;

  out_word_t layouts_due[$];

  task automatic capture_byte(input logic [7:0] b);
    case (offset)
      OFS_SECTOR_SIZE:             bps[7:0]             = b;
      OFS_SECTOR_SIZE + 9'd1:      bps[15:8]            = b;
      OFS_CLUSTER_SECS:            spc                  = b;
      OFS_RESERVED:                rsv[7:0]             = b;
      OFS_RESERVED + 9'd1:         rsv[15:8]            = b;
      OFS_FAT_COUNT:               nfats                = b;
      OFS_ROOT_ENTRIES:            root_entries[7:0]    = b;
      OFS_ROOT_ENTRIES + 9'd1:     root_entries[15:8]   = b;
      OFS_TOTAL_SHORT:             total_short[7:0]     = b;
      OFS_TOTAL_SHORT + 9'd1:      total_short[15:8]    = b;
      OFS_FAT_SIZE_SHORT:          fat_size_short[7:0]  = b;
      OFS_FAT_SIZE_SHORT + 9'd1:   fat_size_short[15:8] = b;
      OFS_TOTAL_LONG:              total_long[7:0]      = b;
      OFS_TOTAL_LONG + 9'd1:       total_long[15:8]     = b;
      OFS_TOTAL_LONG + 9'd2:       total_long[23:16]    = b;
      OFS_TOTAL_LONG + 9'd3:       total_long[31:24]    = b;
      OFS_FAT_SIZE_LONG:           fat_size_long[7:0]   = b;
      OFS_FAT_SIZE_LONG + 9'd1:    fat_size_long[15:8]  = b;
      OFS_FAT_SIZE_LONG + 9'd2:    fat_size_long[23:16] = b;
      OFS_FAT_SIZE_LONG + 9'd3:    fat_size_long[31:24] = b;
      OFS_ROOT_CLUSTER:            root_cluster[7:0]    = b;
      OFS_ROOT_CLUSTER + 9'd1:     root_cluster[15:8]   = b;
      OFS_ROOT_CLUSTER + 9'd2:     root_cluster[23:16]  = b;
      OFS_ROOT_CLUSTER + 9'd3:     root_cluster[31:24]  = b;
      default: ;
    endcase
  endtask

  // Layout of the volume from the fields captured so far.
  function automatic out_word_t predict_layout();
    out_word_t   w;
    logic [31:0] total;
    logic [31:0] fat_size;
    logic [31:0] clusters;
    logic [39:0] fat_secs;
    logic [40:0] root_start;
    logic [63:0] root_secs;
    logic [1:0]  kind;
    total    = (total_short != 0) ? {16'd0, total_short} : total_long;
    fat_size = (fat_size_short != 0) ? {16'd0, fat_size_short} : fat_size_long;
    clusters = (spc != 0) ? total / {24'd0, spc} : 32'd0;
    if (clusters < fat12_limit) begin
      kind = KIND_FAT12;
    end else if (clusters < fat16_limit) begin
      kind = KIND_FAT16;
    end else begin
      kind = KIND_FAT32;
    end
    fat_secs   = {8'd0, fat_size} * {32'd0, nfats};
    root_start = {25'd0, rsv} + {1'b0, fat_secs};
    root_secs  = (bps != 0)
      ? ({48'd0, root_entries} * DIR_ENTRY_BYTES + {48'd0, bps} - 64'd1) / {48'd0, bps}
      : 64'd0;
    w.fat_kind            = kind;
    w.sector_size         = bps;
    w.cluster_sectors     = spc;
    w.fat_region_start    = rsv;
    w.fat_region_sectors  = fat_secs;
    w.root_region_start   = root_start;
    w.root_region_sectors = root_secs[20:0];
    w.data_region_start   = root_start + root_secs[40:0];
    w.root_start_cluster  = (kind == KIND_FAT32) ? root_cluster : 32'd0;
    w.cluster_total       = clusters;
    w.geometry_error      = (bps == 0) || (spc == 0);
    return w;
  endfunction

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("%0t: layout %0d field %s: expected %0h, got %0h",
                 $realtime, layouts_checked, name, want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      fat12_limit     = FAT12_LIMIT_RESET;
      fat16_limit     = FAT16_LIMIT_RESET;
      offset          = '0;
      bps             = '0;
      spc             = '0;
      rsv             = '0;
      nfats           = '0;
      root_entries    = '0;
      total_short     = '0;
      fat_size_short  = '0;
      total_long      = '0;
      fat_size_long   = '0;
      root_cluster    = '0;
      mismatch_count  = 0;
      layouts_checked = 0;
      layouts_due.delete();
    end else begin
      // The back end lies behind the queue and its own registers, so an output word
      // never belongs to a byte accepted at the same edge.
      if (out_valid && !out_stall) begin
        if (layouts_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: layout word with none expected: %h", $realtime, out_data);
          end
        end else begin
          want = layouts_due.pop_front();
          check_field("fat_kind", out_data.fat_kind, want.fat_kind);
          check_field("sector_size", out_data.sector_size, want.sector_size);
          check_field("cluster_sectors", out_data.cluster_sectors, want.cluster_sectors);
          check_field("fat_region_start", out_data.fat_region_start,
                      want.fat_region_start);
          check_field("fat_region_sectors", out_data.fat_region_sectors,
                      want.fat_region_sectors);
          check_field("root_region_start", out_data.root_region_start,
                      want.root_region_start);
          check_field("root_region_sectors", out_data.root_region_sectors,
                      want.root_region_sectors);
          check_field("data_region_start", out_data.data_region_start,
                      want.data_region_start);
          check_field("root_start_cluster", out_data.root_start_cluster,
                      want.root_start_cluster);
          check_field("cluster_total", out_data.cluster_total, want.cluster_total);
          check_field("geometry_error", out_data.geometry_error, want.geometry_error);
          layouts_checked++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_FAT12_LIMIT) begin
          fat12_limit = cfg_data;
        end else begin
          fat16_limit = cfg_data;
        end
      end
      if (in_valid && !in_stall) begin
        capture_byte(in_data.sector_byte);
        if (offset != OFFSET_MAX) begin
          offset++;
        end
        if (in_data.sector_end) begin
          layouts_due.push_back(predict_layout());
          offset = '0;
        end
      end
    end
    layouts_waiting = layouts_due.size();
  end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import fbsl_pkg::*;

  typedef struct {
    logic [15:0] bps;
    logic [7:0]  spc;
    logic [15:0] rsv;
    logic [7:0]  nfats;
    logic [15:0] entries;
    logic [15:0] tot16;
    logic [15:0] fsz16;
    logic [31:0] tot32;
    logic [31:0] fsz32;
    logic [31:0] rootclus;
  } bpb_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_word_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_FAT12_LIMIT;
  logic [31:0] cfg_data  = '0;

  int   mismatches;
  int   waiting;
  int   checked;
  int   bytes_sent     = 0;
  int   sectors_sent   = 0;
  int   limit_settings = 1;
  logic quiet          = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  fat_boot_sector_layout dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  fbsl_checker layout_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatches),
    .layouts_waiting (waiting),
    .layouts_checked (checked)
  );

  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 35);
  end

  // Mostly log-uniform values, with zero, one and all ones mixed in.
  function automatic logic [31:0] spread(input int bits);
    case ($urandom_range(9))
      0:       return '0;
      1:       return 32'hFFFF_FFFF >> (32 - bits);
      2:       return 32'd1;
      default: return $urandom >> $urandom_range(31, 32 - bits);
    endcase
  endfunction

  function automatic bpb_t make_bpb(input logic [15:0] bps, input logic [7:0] spc,
                                    input logic [15:0] rsv, input logic [7:0] nfats,
                                    input logic [15:0] entries, input logic [15:0] tot16,
                                    input logic [15:0] fsz16, input logic [31:0] tot32,
                                    input logic [31:0] fsz32, input logic [31:0] rootclus);
    bpb_t f;
    f.bps = bps;
    f.spc = spc;
    f.rsv = rsv;
    f.nfats = nfats;
    f.entries = entries;
    f.tot16 = tot16;
    f.fsz16 = fsz16;
    f.tot32 = tot32;
    f.fsz32 = fsz32;
    f.rootclus = rootclus;
    return f;
  endfunction

  function automatic bpb_t random_bpb();
    bpb_t f;
    if ($urandom_range(9) == 0) begin
      // Plain noise in every field.
      f = make_bpb(16'($urandom), 8'($urandom), 16'($urandom), 8'($urandom),
                   16'($urandom), 16'($urandom), 16'($urandom), $urandom,
                   $urandom, $urandom);
    end else begin
      f.bps      = $urandom_range(1) ? (16'd32 << $urandom_range(7)) : 16'(spread(16));
      f.spc      = $urandom_range(1) ? (8'd1 << $urandom_range(7)) : 8'(spread(8));
      f.rsv      = 16'(spread(16));
      f.nfats    = $urandom_range(1) ? 8'($urandom_range(1, 2)) : 8'(spread(8));
      f.entries  = 16'(spread(16));
      f.tot16    = ($urandom_range(9) < 4) ? 16'd0 : 16'(spread(16));
      f.fsz16    = ($urandom_range(9) < 4) ? 16'd0 : 16'(spread(16));
      f.tot32    = spread(32);
      f.fsz32    = spread(32);
      f.rootclus = spread(32);
    end
    return f;
  endfunction

  function automatic logic [7:0] bpb_byte(input bpb_t f, input int off);
    case (off)
      OFS_SECTOR_SIZE:          return f.bps[7:0];
      OFS_SECTOR_SIZE + 1:      return f.bps[15:8];
      OFS_CLUSTER_SECS:         return f.spc;
      OFS_RESERVED:             return f.rsv[7:0];
      OFS_RESERVED + 1:         return f.rsv[15:8];
      OFS_FAT_COUNT:            return f.nfats;
      OFS_ROOT_ENTRIES:         return f.entries[7:0];
      OFS_ROOT_ENTRIES + 1:     return f.entries[15:8];
      OFS_TOTAL_SHORT:          return f.tot16[7:0];
      OFS_TOTAL_SHORT + 1:      return f.tot16[15:8];
      OFS_FAT_SIZE_SHORT:       return f.fsz16[7:0];
      OFS_FAT_SIZE_SHORT + 1:   return f.fsz16[15:8];
      OFS_TOTAL_LONG:           return f.tot32[7:0];
      OFS_TOTAL_LONG + 1:       return f.tot32[15:8];
      OFS_TOTAL_LONG + 2:       return f.tot32[23:16];
      OFS_TOTAL_LONG + 3:       return f.tot32[31:24];
      OFS_FAT_SIZE_LONG:        return f.fsz32[7:0];
      OFS_FAT_SIZE_LONG + 1:    return f.fsz32[15:8];
      OFS_FAT_SIZE_LONG + 2:    return f.fsz32[23:16];
      OFS_FAT_SIZE_LONG + 3:    return f.fsz32[31:24];
      OFS_ROOT_CLUSTER:         return f.rootclus[7:0];
      OFS_ROOT_CLUSTER + 1:     return f.rootclus[15:8];
      OFS_ROOT_CLUSTER + 2:     return f.rootclus[23:16];
      OFS_ROOT_CLUSTER + 3:     return f.rootclus[31:24];
      default:                  return 8'($urandom);
    endcase
  endfunction

  // Holds the word on the bus until the block takes it.
  task automatic push_byte(input logic [7:0] b, input logic last);
    while (!quiet && ($urandom_range(99) < 35)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid             <= 1'b1;
    in_data.sector_byte  <= b;
    in_data.sector_end   <= last;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic stream_sector(input bpb_t f, input int len);
    for (int off = 0; off < len; off++) begin
      push_byte(bpb_byte(f, off), off == len - 1);
    end
    sectors_sent++;
  endtask

  task automatic random_sector();
    int pick;
    int len;
    pick = $urandom_range(99);
    if (pick < 70) begin
      len = 48;
    end else if (pick < 85) begin
      len = $urandom_range(1, 47);
    end else if (pick < 99) begin
      len = $urandom_range(49, 90);
    end else begin
      len = $urandom_range(500, 530);
    end
    stream_sector(random_bpb(), len);
  endtask

  // Waits for every expected layout, then lets the back end settle.
  task automatic wait_drained(input int settle);
    in_valid <= 1'b0;
    do @(negedge clk); while (waiting != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_limits(input logic [31:0] fat12, input logic [31:0] fat16);
    cfg_write(CFG_FAT12_LIMIT, fat12);
    cfg_write(CFG_FAT16_LIMIT, fat16);
    limit_settings++;
  endtask

  initial begin
    int phase_bytes;
    int phase_sectors;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A one-byte sector straight after reset sees only zero fields.
    stream_sector(random_bpb(), 1);
    stream_sector(make_bpb(16'd512, 8'd1, 16'd1, 8'd2, 16'd224, 16'd2880, 16'd9,
                           32'd0, 32'd0, 32'd0), 48);
    stream_sector(make_bpb(16'd512, 8'd4, 16'd4, 8'd2, 16'd512, 16'd0, 16'd200,
                           32'd200000, 32'd0, 32'd0), 48);
    // Every field at its extreme, with both short fields falling back.
    stream_sector(make_bpb(16'd1, 8'd1, 16'hFFFF, 8'hFF, 16'hFFFF, 16'd0, 16'd0,
                           32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 48);
    stream_sector(make_bpb(16'd4096, 8'd0, 16'd32, 8'd2, 16'd512, 16'd0, 16'd0,
                           32'd1000000, 32'd1000, 32'd2), 48);
    stream_sector(make_bpb(16'd0, 8'd8, 16'd32, 8'd2, 16'd512, 16'd0, 16'd0,
                           32'd1000000, 32'd1000, 32'd2), 48);
    // Ends right after the cluster size; the rest is held from before.
    stream_sector(make_bpb(16'd2048, 8'd64, 16'd0, 8'd0, 16'd0, 16'd0, 16'd0,
                           32'd0, 32'd0, 32'd0), 14);
    stream_sector(random_bpb(), 520);
    stream_sector(make_bpb(16'd512, 8'd8, 16'd32, 8'd2, 16'd0, 16'd0, 16'd0,
                           32'd2000000, 32'd2000, 32'd2), 48);

    for (int phase = 0; phase < 7; phase++) begin
      if (phase != 0) begin
        wait_drained(40);
        case (phase)
          1:       set_limits(32'd0, 32'd0);
          2:       set_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF);
          3:       set_limits(FAT16_LIMIT_RESET, FAT12_LIMIT_RESET);
          4:       set_limits(32'd0, 32'hFFFF_FFFF);
          5:       set_limits(spread(32), spread(32));
          default: set_limits(FAT12_LIMIT_RESET, FAT16_LIMIT_RESET);
        endcase
      end
      quiet <= (phase == 2);
      phase_bytes   = bytes_sent;
      phase_sectors = sectors_sent;
      while (bytes_sent - phase_bytes < 100 || sectors_sent - phase_sectors < 2) begin
        random_sector();
      end
    end
    wait_drained(40);

    $display("Streamed %0d bytes in %0d boot sectors under %0d cluster limit settings.",
             bytes_sent, sectors_sent, limit_settings);
    $display("Compared %0d layout words field by field; %0d mismatches.",
             checked, mismatches);
    if (mismatches == 0 && waiting == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Timed out with %0d layouts outstanding.", waiting);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
